FILE: design/ewl_pkg.sv
// Package for the EEPROM wear-level ring controller: constants, codes and
// the packed transaction types shared by the RTL.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ewl_pkg;

  localparam int SLOTS        = 19;
  localparam int RECORD_BYTES = 8;

  localparam int SLOT_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int REC_W   = 64;
  localparam int CFG_IDX_W = 1;
  // result counter: up to RECORD_BYTES + 2 results per transaction
  localparam int CNT_W   = $clog2(RECORD_BYTES + 3);

  localparam logic [BYTE_W-1:0] STATUS_BASE_RST    = 8'd152;
  localparam logic [BYTE_W-1:0] FIRST_USE_ADDR_RST = 8'd171;
  localparam logic [BYTE_W-1:0] FIRST_USE_MARK     = 8'hFF;
  localparam logic [BYTE_W-1:0] FIRST_USE_CLEAR    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_STATUS_BASE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_USE_ADDR = 1'd1;

  typedef enum logic [1:0] {
    OP_STATUS    = 2'd0,
    OP_FIRST_USE = 2'd1,
    OP_SAVE      = 2'd2,
    OP_LOAD      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_NO_DATA = 2'd3
  } kind_t;

  typedef struct packed {
    op_t              operation;
    logic [BYTE_W-1:0] read_value;
    logic [REC_W-1:0]  record;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic [SLOT_W-1:0] position;
    logic              scan_finished;
    logic              fresh_device;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

FILE: design/eeprom_wear_level_ring.sv
// EEPROM wear-level ring controller: ring position recovery, save and load
// command generation. Depends on ewl_pkg.
// The first result is registered and appears in the cycle after start is accepted;
// further results follow back to back, one per cycle. Results per transaction: 1 for status and
// first-use bytes, 9 or 10 for a save, 8 for a load (1 on a fresh device), all on the
// single result port.
// busy is high while later results of the transaction remain; start is taken when busy
// is low, including in the cycle that shows a final result. Synchronous reset clears the
// control and ring state, not payload; it sets status_base 152 and first_use_address 171.
`timescale 1ns / 1ps
`default_nettype none

module eeprom_wear_level_ring (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire ewl_pkg::item_t                     item,
  input  wire logic                               cfg_write_en,
  input  wire logic [ewl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ewl_pkg::BYTE_W-1:0]         cfg_data,
  output      logic                               result_strobe,
  output      ewl_pkg::result_t                   result
);

  localparam int CW = ewl_pkg::CNT_W;
  localparam int SW = ewl_pkg::SLOT_W;
  localparam int BW = ewl_pkg::BYTE_W;

  // configuration
  logic [BW-1:0] status_base;
  logic [BW-1:0] first_use_address;

  // ring state
  logic [SW-1:0] slot_pointer, slot_pointer_next;
  logic [BW-1:0] sequence_value, sequence_value_next;
  logic          first_write_flag, first_write_flag_next;
  logic [SW-1:0] scan_index, scan_index_next;
  logic [BW-1:0] scan_previous, scan_previous_next;
  logic          scan_done_flag, scan_done_flag_next;

  // transaction held for the remaining results
  ewl_pkg::op_t                op_q;
  logic [ewl_pkg::REC_W-1:0]   rec_q;
  logic [BW-1:0]               base_q;
  logic                        flag_q;   // save: clear first-use; load: no data
  logic [CW-1:0]               idx, idx_next;
  logic [CW-1:0]               rem, rem_next;

  logic                        accept;
  logic [SW-1:0]               prev_slot;
  logic [BW-1:0]               in_base;
  logic                        in_flag;
  logic [CW-1:0]               in_count;

  ewl_pkg::op_t                g_op;
  logic [ewl_pkg::REC_W-1:0]   g_rec;
  logic [BW-1:0]               g_base;
  logic                        g_flag;
  logic [CW-1:0]               g_idx;
  logic                        g_active;
  ewl_pkg::result_t            g_res;

  assign busy   = (rem != '0);
  assign accept = start && !busy;

  assign prev_slot = (slot_pointer == '0) ? SW'(ewl_pkg::SLOTS - 1) : slot_pointer - 1'b1;

  // per-transaction setup from the incoming item and the state before it
  always_comb begin
    in_base  = '0;
    in_flag  = 1'b0;
    in_count = CW'(1);
    unique case (item.operation)
      ewl_pkg::OP_STATUS, ewl_pkg::OP_FIRST_USE: begin
        in_count = CW'(1);
      end
      ewl_pkg::OP_SAVE: begin
        in_base  = BW'(slot_pointer * ewl_pkg::RECORD_BYTES);
        in_flag  = first_write_flag;
        in_count = first_write_flag ? CW'(ewl_pkg::RECORD_BYTES + 2)
                                    : CW'(ewl_pkg::RECORD_BYTES + 1);
      end
      ewl_pkg::OP_LOAD: begin
        in_base  = BW'(prev_slot * ewl_pkg::RECORD_BYTES);
        in_flag  = first_write_flag;
        in_count = first_write_flag ? CW'(1) : CW'(ewl_pkg::RECORD_BYTES);
      end
      default: in_count = CW'(1);
    endcase
  end

  // state update on accept
  always_comb begin
    slot_pointer_next     = slot_pointer;
    sequence_value_next   = sequence_value;
    first_write_flag_next = first_write_flag;
    scan_index_next       = scan_index;
    scan_previous_next    = scan_previous;
    scan_done_flag_next   = scan_done_flag;
    if (accept) begin
      unique case (item.operation)
        ewl_pkg::OP_STATUS: begin
          if (!scan_done_flag) begin
            if (scan_index == '0) begin
              scan_previous_next = item.read_value;
              scan_index_next    = SW'(1);
            end else if (item.read_value == scan_previous + 1'b1) begin
              scan_previous_next = item.read_value;
              if (scan_index >= SW'(ewl_pkg::SLOTS)) begin
                scan_done_flag_next = 1'b1;
              end else begin
                scan_index_next = scan_index + 1'b1;
              end
            end else begin
              // chain break: position is the slot before the break
              slot_pointer_next   = scan_index - 1'b1;
              sequence_value_next = scan_previous;
              scan_done_flag_next = 1'b1;
            end
          end
        end
        ewl_pkg::OP_FIRST_USE: begin
          if (slot_pointer == '0 && item.read_value == ewl_pkg::FIRST_USE_MARK) begin
            first_write_flag_next = 1'b1;
          end
        end
        ewl_pkg::OP_SAVE: begin
          slot_pointer_next     = (slot_pointer == SW'(ewl_pkg::SLOTS - 1)) ? '0
                                : slot_pointer + 1'b1;
          sequence_value_next   = sequence_value + 1'b1;
          first_write_flag_next = 1'b0;
        end
        ewl_pkg::OP_LOAD: begin
          first_write_flag_next = first_write_flag;
        end
        default: ;
      endcase
    end
  end

  // result generation: the first result comes from the incoming item,
  // later ones from the held transaction
  always_comb begin
    g_op     = accept ? item.operation : op_q;
    g_rec    = accept ? item.record    : rec_q;
    g_base   = accept ? in_base        : base_q;
    g_flag   = accept ? in_flag        : flag_q;
    g_idx    = accept ? '0             : idx;
    g_active = accept || busy;
    rem_next = accept ? in_count - 1'b1 : (busy ? rem - 1'b1 : '0);
    idx_next = g_idx + 1'b1;

    g_res               = '0;
    g_res.position      = slot_pointer_next;
    g_res.scan_finished = scan_done_flag_next;
    g_res.fresh_device  = first_write_flag_next;
    g_res.last          = (rem_next == '0);
    unique case (g_op)
      ewl_pkg::OP_STATUS, ewl_pkg::OP_FIRST_USE: begin
        g_res.kind = ewl_pkg::KIND_STATUS;
      end
      ewl_pkg::OP_SAVE: begin
        g_res.kind = ewl_pkg::KIND_WRITE;
        if (g_idx < CW'(ewl_pkg::RECORD_BYTES)) begin
          g_res.address    = g_base + BW'(g_idx);
          g_res.write_data = BW'(g_rec >> {g_idx, 3'b000});
        end else if (g_idx == CW'(ewl_pkg::RECORD_BYTES)) begin
          g_res.address    = status_base + BW'(slot_pointer_next);
          g_res.write_data = sequence_value_next;
        end else begin
          g_res.address    = first_use_address;
          g_res.write_data = ewl_pkg::FIRST_USE_CLEAR;
        end
      end
      ewl_pkg::OP_LOAD: begin
        if (g_flag) begin
          g_res.kind = ewl_pkg::KIND_NO_DATA;
        end else begin
          g_res.kind    = ewl_pkg::KIND_READ;
          g_res.address = g_base + BW'(g_idx);
        end
      end
      default: g_res.kind = ewl_pkg::KIND_STATUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_base       <= ewl_pkg::STATUS_BASE_RST;
      first_use_address <= ewl_pkg::FIRST_USE_ADDR_RST;
      slot_pointer      <= '0;
      sequence_value    <= '0;
      first_write_flag  <= 1'b0;
      scan_index        <= '0;
      scan_previous     <= '0;
      scan_done_flag    <= 1'b0;
      rem               <= '0;
      idx               <= '0;
      result_strobe     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          ewl_pkg::REG_STATUS_BASE:    status_base       <= cfg_data;
          ewl_pkg::REG_FIRST_USE_ADDR: first_use_address <= cfg_data;
          default: ;
        endcase
      end
      slot_pointer     <= slot_pointer_next;
      sequence_value   <= sequence_value_next;
      first_write_flag <= first_write_flag_next;
      scan_index       <= scan_index_next;
      scan_previous    <= scan_previous_next;
      scan_done_flag   <= scan_done_flag_next;
      rem              <= rem_next;
      idx              <= idx_next;
      result_strobe    <= g_active;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= item.operation;
      rec_q  <= item.record;
      base_q <= in_base;
      flag_q <= in_flag;
    end
    if (g_active) begin
      result <= g_res;
    end
  end

  // a started transaction shows its first result in the next cycle
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_strobe)
    else $error("no result after accepted transaction");

  // pending results come out back to back
  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> result_strobe)
    else $error("gap in result sequence");

  // a result that is not the final one leaves more results pending
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |-> busy)
    else $error("non-final result with nothing pending");

  // ring position stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_pointer < SW'(ewl_pkg::SLOTS))
    else $error("slot pointer out of range");

  // no transaction can run longer than a save with first-use clear
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem <= CW'(ewl_pkg::RECORD_BYTES + 1))
    else $error("result count out of range");

endmodule

`default_nettype wire

FILE: tb/tb_eeprom_wear_level_ring.sv
// Self-checking testbench for eeprom_wear_level_ring: ring recovery scan, save and
// load command sequences, checked against an in-bench predictor of the command stream.
// Depends on ewl_pkg and the eeprom_wear_level_ring RTL.
`timescale 1ns / 1ps

module tb_eeprom_wear_level_ring;
  import ewl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int          PHASE_ITEMS = 89;

  // Predicts the command/report stream of the ring controller and checks it
  class ring_scoreboard;
    logic [BYTE_W-1:0] status_base;
    logic [BYTE_W-1:0] first_use_addr;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] seq;
    logic              fresh;
    logic [SLOT_W-1:0] scan_idx;
    logic [BYTE_W-1:0] scan_prev;
    logic              scan_done;
    result_t           step_out[$];
    result_t           pending_cmds[$];
    int                errors;

    function new();
      status_base    = STATUS_BASE_RST;
      first_use_addr = FIRST_USE_ADDR_RST;
      slot      = '0;
      seq       = '0;
      fresh     = 1'b0;
      scan_idx  = '0;
      scan_prev = '0;
      scan_done = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      if (idx == REG_STATUS_BASE) status_base = data;
      else first_use_addr = data;
    endfunction

    function void emit(kind_t k, logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] data);
      result_t r;
      r = '0;
      r.kind       = k;
      r.address    = addr;
      r.write_data = data;
      step_out.push_back(r);
    endfunction

    function void predict_commands(item_t it);
      int i;
      int prev;
      step_out.delete();
      case (it.operation)
        OP_STATUS: begin
          if (!scan_done) begin
            if (scan_idx == 0) begin
              scan_prev = it.read_value;
              scan_idx  = 1;
            end else if (it.read_value == scan_prev + 8'd1) begin
              scan_prev = it.read_value;
              // chain ran through every slot without a break
              if (scan_idx >= SLOTS) scan_done = 1'b1;
              else scan_idx = scan_idx + 1'b1;
            end else begin
              slot      = scan_idx - 1'b1;
              seq       = scan_prev;
              scan_done = 1'b1;
            end
          end
          emit(KIND_STATUS, '0, '0);
        end
        OP_FIRST_USE: begin
          if (slot == 0 && it.read_value == FIRST_USE_MARK) fresh = 1'b1;
          emit(KIND_STATUS, '0, '0);
        end
        OP_SAVE: begin
          for (i = 0; i < RECORD_BYTES; i++)
            emit(KIND_WRITE, 8'(slot * RECORD_BYTES + i), it.record[8*i +: 8]);
          slot = (slot == SLOTS - 1) ? '0 : slot + 1'b1;
          seq  = seq + 8'd1;
          emit(KIND_WRITE, status_base + {3'b000, slot}, seq);
          if (fresh) begin
            emit(KIND_WRITE, first_use_addr, FIRST_USE_CLEAR);
            fresh = 1'b0;
          end
        end
        default: begin
          if (fresh) begin
            emit(KIND_NO_DATA, '0, '0);
          end else begin
            prev = (int'(slot) + SLOTS - 1) % SLOTS;
            for (i = 0; i < RECORD_BYTES; i++)
              emit(KIND_READ, 8'(prev * RECORD_BYTES + i), '0);
          end
        end
      endcase
      foreach (step_out[j]) begin
        step_out[j].position      = slot;
        step_out[j].scan_finished = scan_done;
        step_out[j].fresh_device  = fresh;
        step_out[j].last          = (j == step_out.size() - 1);
        pending_cmds.push_back(step_out[j]);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_command(result_t act);
      result_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: result with no transaction outstanding: expected none, actual %h",
                 $time, act);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      check_field("kind", want.kind, act.kind);
      check_field("address", want.address, act.address);
      check_field("write_data", want.write_data, act.write_data);
      check_field("position", want.position, act.position);
      check_field("scan_finished", want.scan_finished, act.scan_finished);
      check_field("fresh_device", want.fresh_device, act.fresh_device);
      check_field("last", want.last, act.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  item_t                 item = '0;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0]     cfg_data = '0;
  logic                  result_strobe;
  result_t               result;

  ring_scoreboard sb;
  int unsigned    cycles = 0;

  eeprom_wear_level_ring u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_eeprom_wear_level_ring: FAIL");
      $finish;
    end
  end

  // results first: a transaction accepted at this edge cannot produce one yet
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) sb.check_command(result);
      if (start && !busy) sb.predict_commands(item);
    end
  end

  function automatic item_t make_item(op_t op, logic [BYTE_W-1:0] rv, logic [REC_W-1:0] rec);
    item_t it;
    it.operation  = op;
    it.read_value = rv;
    it.record     = rec;
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned sel;
    logic [REC_W-1:0] rec;
    logic [BYTE_W-1:0] rv;
    sel = $urandom_range(0, 99);
    rv  = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       rec = '0;
      1:       rec = '1;
      default: rec = {$urandom, $urandom};
    endcase
    if (sel < 8) return make_item(OP_STATUS, rv, rec);
    if (sel < 22) begin
      if ($urandom_range(0, 1) == 0) rv = FIRST_USE_MARK;
      return make_item(OP_FIRST_USE, rv, rec);
    end
    if (sel < 62) return make_item(OP_SAVE, rv, rec);
    return make_item(OP_LOAD, rv, rec);
  endfunction

  // holds start until the transaction is taken; start stays high on return
  task automatic send(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < count; b++) begin
        send(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] v;
    int                brk;
    logic [BYTE_W-1:0] base_val;
    logic [BYTE_W-1:0] fu_val;

    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before the scan: load on a used device, mark fresh, load with no data, fresh save
    send(make_item(OP_LOAD, 8'h00, '0));
    send(make_item(OP_FIRST_USE, FIRST_USE_MARK, '1));
    send(make_item(OP_LOAD, 8'hFF, '0));
    send(make_item(OP_SAVE, 8'h00, '1));

    // recovery scan; break position 19 means the chain never breaks
    brk = $urandom_range(0, 19);
    v   = 8'($urandom_range(236, 255));
    send(make_item(OP_STATUS, v, '0));
    for (int k = 0; k < SLOTS; k++) begin
      if (k == brk) v = v + 8'($urandom_range(2, 255));
      else v = v + 8'd1;
      send(make_item(OP_STATUS, v, '1));
      if (k == brk) break;
    end
    send(make_item(OP_STATUS, 8'hFF, '0));   // after the scan: report only

    send(make_item(OP_FIRST_USE, 8'h00, '0));
    send(make_item(OP_FIRST_USE, FIRST_USE_MARK, '0));
    send(make_item(OP_SAVE, 8'hFF, '0));
    send(make_item(OP_SAVE, 8'h00, 64'h0123_4567_89AB_CDEF));
    send(make_item(OP_LOAD, 8'h00, '1));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin base_val = 8'h00; fu_val = 8'hFF; end
        1: begin base_val = 8'hFF; fu_val = 8'h00; end
        default: begin base_val = 8'($urandom); fu_val = 8'($urandom); end
      endcase
      write_reg(REG_STATUS_BASE, base_val);
      write_reg(REG_FIRST_USE_ADDR, fu_val);
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending_cmds.size() != 0) begin
      $display("%0t: results outstanding at end: expected 0, actual %0d", $time,
               sb.pending_cmds.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("tb_eeprom_wear_level_ring: PASS");
    else $display("tb_eeprom_wear_level_ring: FAIL");
    $finish;
  end

endmodule
